[hdl/periodic_task_release_timer_top_macros.svh]
// Assertion macros shared by the periodic task release timer RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef PERIODIC_TASK_RELEASE_TIMER_TOP_MACROS_SVH
`define PERIODIC_TASK_RELEASE_TIMER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define PRTT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("prtt assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define PRTT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("prtt assertion failed");

`endif

[hdl/prtt_pkg.sv]
// Package for the periodic task release timer: widths, register codes,
// the slot control struct and the saturating counter add. No dependencies.
package prtt_pkg;

    localparam int NUM_TASKS_DEF = 4;

    localparam int ELAPSED_W   = 16;
    localparam int CNT_W       = 17;
    localparam int TIMING_W    = 32;
    localparam int HALF_W      = 16;
    localparam int TIMING_REGS = 4;
    localparam int COUNT_W     = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int MASK_W      = 4;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Register indexes: task count, then one timing register per slot, TIMING_REGS of them
    localparam logic [CFG_IDX_W-1:0] CFG_TASK_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMING_BASE = 3'd1;

    // Per-slot control from the top level
    typedef struct packed {
        logic step;     // poll item moves from input stage to output stage
        logic enabled;  // slot lies below the enabled task count
    } t_slot_ctrl;

    // Counter plus elapsed time, clamped at the counter maximum
    function automatic logic [CNT_W-1:0] sat_add(
        input logic [CNT_W-1:0]     a,
        input logic [ELAPSED_W-1:0] b
    );
        logic [CNT_W:0] s;
        s = {1'b0, a} + {{(CNT_W - ELAPSED_W + 1){1'b0}}, b};
        return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
    endfunction

endpackage

[hdl/prtt_task_slot.sv]
// One task slot: time-since-release counter, offset-consumed flag, release test.
// Depends on prtt_pkg and periodic_task_release_timer_top_macros.svh.
`include "periodic_task_release_timer_top_macros.svh"

module prtt_task_slot (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  prtt_pkg::t_slot_ctrl             i_ctrl,
    input  logic [prtt_pkg::ELAPSED_W-1:0]   i_elapsed,
    input  logic [prtt_pkg::CNT_W-1:0]       i_tss_new,
    input  logic [prtt_pkg::TIMING_W-1:0]    i_timing,
    output logic                             o_fire
);
    import prtt_pkg::*;

    logic [CNT_W-1:0]  r_tsr;
    logic [CNT_W-1:0]  n_tsr;
    logic              r_offset_done;
    logic              n_offset_done;
    logic [HALF_W-1:0] w_period;
    logic [HALF_W-1:0] w_offset;
    logic [CNT_W-1:0]  w_tsr_adv;

    assign w_period  = i_timing[HALF_W-1:0];
    assign w_offset  = i_timing[TIMING_W-1:HALF_W];
    assign w_tsr_adv = sat_add(r_tsr, i_elapsed);

    // Release test against the advanced counters
    always_comb begin
        o_fire = 1'b0;
        if (i_ctrl.enabled) begin
            if (!r_offset_done) begin
                o_fire = ({1'b0, w_offset} <= i_tss_new);
            end else begin
                o_fire = ({1'b0, w_period} <= w_tsr_adv);
            end
        end
    end

    // A release clears the counter and consumes the offset
    always_comb begin
        n_tsr         = o_fire ? '0 : w_tsr_adv;
        n_offset_done = r_offset_done | o_fire;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tsr         <= '0;
            r_offset_done <= 1'b0;
        end else if (i_ctrl.step) begin
            r_tsr         <= n_tsr;
            r_offset_done <= n_offset_done;
        end
    end

    `PRTT_ASSERT_NEXT(a_offset_sticky, i_clk, i_rst_n, r_offset_done, r_offset_done)
    `PRTT_ASSERT_NEXT(a_fire_clears, i_clk, i_rst_n, i_ctrl.step && o_fire, r_tsr == '0)
    `PRTT_ASSERT_NEXT(a_tsr_grows, i_clk, i_rst_n, i_ctrl.step && !o_fire,
        r_tsr >= $past(r_tsr))

endmodule

[hdl/periodic_task_release_timer_top.sv]
// Top level of the periodic task release timer: handshakes, config registers,
// time-since-start counter and task slots. Depends on prtt_pkg, prtt_task_slot.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+------------------------------
//  poll    | in  | i_in_valid / o_in_ready | i_elapsed_ms [15:0]
//  release | out | o_out_valid / i_out_ready | o_release_mask [3:0]
//  config  | in  | i_cfg_we (no wait)      | i_cfg_index [2:0], i_cfg_wdata [31:0]
//
// One poll item per cycle sustained while the output is not stalled; o_out_valid rises
// once the item has passed the input register and the counter update into the result register.
// Reset (synchronous, active low) clears all counters, flags, valids and config registers.
// When the output stalls, the input register still takes one more item;
// after that o_in_ready drops until the result register is drained.
`include "periodic_task_release_timer_top_macros.svh"

module periodic_task_release_timer_top #(
    parameter int NUM_TASKS = prtt_pkg::NUM_TASKS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [prtt_pkg::ELAPSED_W-1:0]    i_elapsed_ms,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [prtt_pkg::MASK_W-1:0]       o_release_mask,
    input  logic                              i_cfg_we,
    input  logic [prtt_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [prtt_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);
    import prtt_pkg::*;

    logic                 r_in_valid;
    logic [ELAPSED_W-1:0] r_elapsed;
    logic                 r_out_valid;
    logic [MASK_W-1:0]    r_mask;
    logic [COUNT_W-1:0]   r_task_count;
    logic [CNT_W-1:0]     r_tss;
    logic [CNT_W-1:0]     n_tss;
    logic                 w_advance;
    logic                 w_in_take;
    logic [NUM_TASKS-1:0] w_fire;
    logic [MASK_W-1:0]    w_mask;
    logic [NUM_TASKS-1:0][TIMING_W-1:0] w_timing;

    // Handshake: input stage advances whenever the result register is free
    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;
    assign w_in_take  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_elapsed <= i_elapsed_ms;
        end
    end

    // Task count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_task_count <= '0;
        end else if (i_cfg_we && (i_cfg_index == CFG_TASK_COUNT)) begin
            r_task_count <= i_cfg_wdata[COUNT_W-1:0];
        end
    end

    // Time since start
    assign n_tss = sat_add(r_tss, r_elapsed);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tss <= '0;
        end else if (w_advance) begin
            r_tss <= n_tss;
        end
    end

    // Task slots; slots beyond the timing registers keep zero timing
    for (genvar g = 0; g < NUM_TASKS; g++) begin : g_slot
        t_slot_ctrl w_ctrl;

        if (g < TIMING_REGS) begin : g_reg
            logic [TIMING_W-1:0] r_timing;
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_timing <= '0;
                end else if (i_cfg_we &&
                             (i_cfg_index == (CFG_TIMING_BASE + CFG_IDX_W'(g)))) begin
                    r_timing <= i_cfg_wdata;
                end
            end
            assign w_timing[g] = r_timing;
        end else begin : g_const
            assign w_timing[g] = '0;
        end

        assign w_ctrl.step    = w_advance;
        assign w_ctrl.enabled = (r_task_count > COUNT_W'(g));

        prtt_task_slot u_slot (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctrl    (w_ctrl),
            .i_elapsed (r_elapsed),
            .i_tss_new (n_tss),
            .i_timing  (w_timing[g]),
            .o_fire    (w_fire[g])
        );
    end

    // Release mask: slots that do not fit the mask are dropped
    for (genvar b = 0; b < MASK_W; b++) begin : g_mask
        if (b < NUM_TASKS) begin : g_bit
            assign w_mask[b] = w_fire[b];
        end else begin : g_zero
            assign w_mask[b] = 1'b0;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_mask <= w_mask;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_release_mask = r_mask;

    `PRTT_ASSERT_NEXT(a_tss_grows, i_clk, i_rst_n, w_advance, r_tss >= $past(r_tss))
    `PRTT_ASSERT_NEXT(a_adv_fills_out, i_clk, i_rst_n, w_advance, r_out_valid)
    `PRTT_ASSERT_NOW(a_full_blocks, i_clk, i_rst_n, r_in_valid && !w_advance, !o_in_ready)

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// Testbench for periodic_task_release_timer_top: sends poll items, programs the
// task registers between phases and checks every release mask against a local
// predictor of the timer state. Depends on prtt_pkg and the RTL top level.

module tb_top;
    import prtt_pkg::*;

    localparam int NUM_SLOTS     = NUM_TASKS_DEF;
    localparam int STALL_LIMIT   = 400;
    localparam int DRAIN_CYCLES  = 4;
    localparam int PHASE_ITEMS   = 130;
    localparam int RANDOM_PHASES = 10;
    localparam int MAX_REPORTS   = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED =
        CFG_TIMING_BASE + CFG_IDX_W'(TIMING_REGS);

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_in_valid    = 1'b0;
    logic                   o_in_ready;
    logic [ELAPSED_W-1:0]   i_elapsed_ms  = '0;
    logic                   o_out_valid;
    logic                   i_out_ready   = 1'b0;
    logic [MASK_W-1:0]      o_release_mask;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata   = '0;

    // Predicted timer state and registers
    logic [COUNT_W-1:0]     task_count_m = '0;
    logic [TIMING_W-1:0]    timing_m [NUM_SLOTS];
    logic [CNT_W-1:0]       since_start = '0;
    logic [CNT_W-1:0]       since_release [NUM_SLOTS];
    logic                   offset_done [NUM_SLOTS];

    logic [MASK_W-1:0]      release_q [$];
    int                     n_errors = 0;
    bit                     idle_on  = 1'b1;

    periodic_task_release_timer_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_elapsed_ms   (i_elapsed_ms),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_release_mask (o_release_mask),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            timing_m[i]      = '0;
            since_release[i] = '0;
            offset_done[i]   = 1'b0;
        end
    end

    // Counter plus elapsed time, held at the counter maximum
    function automatic logic [CNT_W-1:0] add_clamped(input logic [CNT_W-1:0] acc,
                                                     input logic [ELAPSED_W-1:0] ms);
        logic [CNT_W:0] total;
        total = {1'b0, acc} + (CNT_W+1)'(ms);
        return (total > (CNT_W+1)'(CNT_MAX)) ? CNT_MAX : total[CNT_W-1:0];
    endfunction

    // Advance the timer by one poll and return the tasks it releases
    function automatic logic [MASK_W-1:0] predict_release_mask(input logic [ELAPSED_W-1:0] ms);
        int                 enabled;
        logic [MASK_W-1:0]  mask;
        logic [HALF_W-1:0]  period;
        logic [HALF_W-1:0]  offset;
        logic               fire;
        enabled = (int'(task_count_m) > NUM_SLOTS) ? NUM_SLOTS : int'(task_count_m);
        mask = '0;
        since_start = add_clamped(since_start, ms);
        for (int i = 0; i < NUM_SLOTS; i++)
            since_release[i] = add_clamped(since_release[i], ms);
        for (int i = 0; i < enabled; i++) begin
            period = timing_m[i][HALF_W-1:0];
            offset = timing_m[i][TIMING_W-1:HALF_W];
            fire   = 1'b0;
            if (!offset_done[i]) begin
                if (CNT_W'(offset) <= since_start) begin
                    fire = 1'b1;
                    offset_done[i] = 1'b1;
                end
            end else if (CNT_W'(period) <= since_release[i]) begin
                fire = 1'b1;
            end
            if (fire) begin
                since_release[i] = '0;
                if (i < MASK_W)
                    mask[i] = 1'b1;
            end
        end
        return mask;
    endfunction

    // Task count word with junk in the unused upper bits
    function automatic logic [CFG_DATA_W-1:0] count_word(input int n);
        return (CFG_DATA_W'($urandom) & ~CFG_DATA_W'((1 << COUNT_W) - 1)) | CFG_DATA_W'(n);
    endfunction

    function automatic void report_mismatch(input string what,
                                            input logic [MASK_W-1:0] want,
                                            input logic [MASK_W-1:0] got);
        n_errors++;
        if (n_errors <= MAX_REPORTS)
            $display("%s: expected %h, got %h", what, want, got);
    endfunction

    // Register write; the block is idle whenever this is called
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_TASK_COUNT)
            task_count_m = data[COUNT_W-1:0];
        else if (idx >= CFG_TIMING_BASE && idx < CFG_FIRST_UNUSED)
            timing_m[idx - CFG_TIMING_BASE] = data;
    endtask

    // Send one poll item, sometimes with a random gap ahead of it while idling is on
    task automatic send_poll(input logic [ELAPSED_W-1:0] ms);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_elapsed_ms <= ms;
        do @(posedge i_clk); while (!o_in_ready);
        release_q.push_back(predict_release_mask(ms));
    endtask

    // Stop sending and wait until every expected mask has come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (release_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Reset values: no task enabled, nothing released
    task automatic test_reset_state();
        send_poll('0);
        send_poll(16'd1);
        send_poll(16'd2);
    endtask

    // Offset release, zero offset and zero period
    task automatic test_offset_release();
        wait_drained();
        cfg_write(CFG_TIMING_BASE,        {16'd10, 16'd5});
        cfg_write(CFG_TIMING_BASE + 3'd1, {16'd0, 16'd0});
        cfg_write(CFG_TASK_COUNT, count_word(2));
        send_poll('0);
        send_poll(16'd4);
        send_poll(16'd3);
        send_poll(16'd2);
        send_poll(16'd5);
        send_poll(16'd1);
        send_poll(16'd4);
    endtask

    // Late-enabled slots, oversized count, unused register indexes
    task automatic test_slot_enable();
        wait_drained();
        for (int idx = CFG_FIRST_UNUSED; idx < (1 << CFG_IDX_W); idx++)
            cfg_write(CFG_IDX_W'(idx), CFG_DATA_W'($urandom));
        cfg_write(CFG_TIMING_BASE + 3'd2, {16'd5, 16'd7});
        cfg_write(CFG_TIMING_BASE + 3'd3, {16'hFFFF, 16'hFFFF});
        cfg_write(CFG_TASK_COUNT, count_word((1 << COUNT_W) - 1));
        send_poll(16'd1);
        send_poll(16'd3);
        send_poll(16'd8);
        send_poll(16'd2);
        wait_drained();
        cfg_write(CFG_TASK_COUNT, count_word(3));
        send_poll(16'd6);
        send_poll(16'd1);
        send_poll(16'd7);
    endtask

    // Largest elapsed values drive the start counter and idle slot counters into saturation
    task automatic test_counter_saturation();
        wait_drained();
        cfg_write(CFG_TIMING_BASE, {16'd0, 16'hFFFF});
        cfg_write(CFG_TASK_COUNT, count_word(1));
        send_poll('1);
        send_poll('1);
        send_poll('1);
        send_poll('0);
        send_poll('1);
        send_poll(16'd1);
    endtask

    // Random register settings, then random polls under each
    task automatic test_random_phases(input int phases);
        logic [HALF_W-1:0]    period;
        logic [HALF_W-1:0]    offset;
        logic [ELAPSED_W-1:0] ms;
        int                   pick;
        for (int p = 0; p < phases; p++) begin
            wait_drained();
            if ($urandom_range(0, 3) == 0)
                cfg_write(CFG_IDX_W'($urandom_range(CFG_FIRST_UNUSED, (1 << CFG_IDX_W) - 1)),
                          CFG_DATA_W'($urandom));
            for (int s = 0; s < TIMING_REGS; s++) begin
                if ($urandom_range(0, 2) != 0) begin
                    pick   = $urandom_range(0, 9);
                    offset = HALF_W'($urandom);
                    if (pick < 6)
                        period = HALF_W'($urandom_range(0, 300));
                    else if (pick < 8)
                        period = HALF_W'($urandom);
                    else
                        period = (pick == 8) ? '0 : '1;
                    cfg_write(CFG_TIMING_BASE + CFG_IDX_W'(s), {offset, period});
                end
            end
            cfg_write(CFG_TASK_COUNT, count_word($urandom_range(0, (1 << COUNT_W) - 1)));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 9);
                if (pick < 7)
                    ms = ELAPSED_W'($urandom_range(0, 40));
                else if (pick < 9)
                    ms = ELAPSED_W'($urandom_range(0, 400));
                else
                    ms = ELAPSED_W'($urandom);
                send_poll(ms);
                // occasionally let the pipeline run dry mid-phase
                if (idle_on && $urandom_range(0, 99) == 0)
                    wait_drained();
            end
        end
    endtask

    // Last stretch at full rate on both sides
    task automatic test_full_rate();
        idle_on = 1'b0;
        test_random_phases(1);
    endtask

    // Main sequence
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_offset_release();
        test_slot_enable();
        test_counter_saturation();
        test_random_phases(RANDOM_PHASES);
        test_full_rate();
        wait_drained();
        if (n_errors == 0 && release_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Receiver readiness: random stalls while idling is on
    initial begin : out_ready_gen
        int span;
        @(posedge i_clk);
        forever begin
            if (idle_on && $urandom_range(0, 2) == 0) begin
                i_out_ready <= 1'b0;
                span = $urandom_range(1, 16);
            end else begin
                i_out_ready <= 1'b1;
                span = $urandom_range(1, 24);
            end
            // a stall ends early once idling is switched off
            repeat (span) begin
                @(posedge i_clk);
                if (!idle_on && !i_out_ready)
                    break;
            end
        end
    end

    // Compare each result item with the oldest prediction
    always @(posedge i_clk) begin : release_check
        logic [MASK_W-1:0] want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (release_q.size() == 0) begin
                report_mismatch("unexpected release item", 'x, o_release_mask);
            end else begin
                want = release_q.pop_front();
                if (o_release_mask !== want)
                    report_mismatch("release mask mismatch", want, o_release_mask);
            end
        end
    end

    // Watchdog on cycles without any transfer
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we
                    || !i_rst_n)
                quiet = 0;
            else
                quiet++;
        end
        $display("== FAIL ==");
        $finish;
    end

endmodule

[sim.f]
+incdir+hdl
hdl/prtt_pkg.sv
hdl/prtt_task_slot.sv
hdl/periodic_task_release_timer_top.sv
sim/tb_top.sv
